// ----- src/stpd_pkg.sv -----
// ----------------------------------------------------------------------------
// stpd_pkg: shared types and constants of the sync pulse tempo detector
// Item structs, register reset values, register indexes and FSM states.
// ----------------------------------------------------------------------------
package stpd_pkg;

  // rate = floor((120000000 + p) / (2p)); bpm = rate >> 1
  localparam logic [31:0] RATE_NUM_X2 = 32'd120000000;

  localparam int unsigned THR_W  = 15;
  localparam int unsigned BPM_W  = 8;
  localparam int unsigned CFG_W  = THR_W;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned CNT_W  = $clog2(DIV_W);
  localparam int unsigned QUO_W  = BPM_W + 1;

  localparam logic [THR_W-1:0] THR_RESET   = 15'd6554;
  localparam logic [BPM_W-1:0] LOW_RESET   = 8'd30;
  localparam logic [BPM_W-1:0] HIGH_RESET  = 8'd240;
  localparam logic [BPM_W-1:0] TEMPO_RESET = 8'd120;

  typedef enum logic [IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LOW_LIMIT = 2'd1,
    CFG_HIGH_LIMIT = 2'd2
  } stpd_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } stpd_state_e;

  typedef struct packed {
    logic signed [15:0] sync_sample;
    logic [31:0]        now_us;
  } stpd_in_t;

  typedef struct packed {
    logic [BPM_W-1:0] tempo_bpm;
    logic             edge_seen;
    logic             tempo_changed;
  } stpd_out_t;

  // front end decision for the item in flight
  typedef struct packed {
    logic take;         // held sample gets replaced
    logic edge_hit;     // qualified rising edge
    logic period_zero;  // timestamp equals the last edge time
  } stpd_eval_t;

  // serial divider result
  typedef struct packed {
    logic             ovf;  // quotient did not fit in QUO_W bits
    logic [QUO_W-1:0] quo;
  } stpd_rate_t;

endpackage

// ----- src/sync_pulse_tempo_detector.sv -----
// ----------------------------------------------------------------------------
// sync_pulse_tempo_detector: tempo from sync pulse period
// Qualifies rising edges on a sync channel and converts their period to bpm.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one item (sample + timestamp).
// Output channel: out_valid_o / out_stall_i carry one result item per input.
// Config: cfg_we_i writes register cfg_idx_i (0 threshold, 1 low limit,
// 2 high limit) with cfg_data_i; index 3 is ignored. Write only while idle.
//
// One item is processed at a time; in_stall_o is high while it is in flight.
// An item without a qualified edge (or with a zero period) passes through
// EVAL, PREP and DONE before the next item can be accepted. An edge item
// also passes DIV: the 32-step serial divider, one quotient bit per cycle.
// The result lands in an output register when the item finishes;
// a new item is accepted while that result waits for the receiver. If the
// receiver stalls, the next result holds in its final state until the
// register frees up, and the block keeps its input stalled meanwhile.
// Reset clears the held sample and edge time, sets tempo to 120 bpm and the
// registers to threshold 6554, limits 30 and 240 bpm.
// ----------------------------------------------------------------------------
module sync_pulse_tempo_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  stpd_pkg::stpd_in_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output stpd_pkg::stpd_out_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [stpd_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [stpd_pkg::CFG_W-1:0]   cfg_data_i
);

  stpd_pkg::stpd_state_e state_q, state_d;

  logic [stpd_pkg::THR_W-1:0] thr_q;
  logic [stpd_pkg::BPM_W-1:0] low_q, high_q, tempo_q, tempo_d;
  logic                       rate_ok_q, rate_ok_d;
  logic                       out_valid_q, out_valid_d;
  stpd_pkg::stpd_out_t        out_q;

  logic                       accept, eval_en, div_start, commit;
  stpd_pkg::stpd_eval_t       eval;
  logic [stpd_pkg::DIV_W-1:0] period;
  logic [stpd_pkg::DIV_W:0]   num_sum;
  logic                       div_done;
  stpd_pkg::stpd_rate_t       rate;
  logic [stpd_pkg::BPM_W-1:0] bpm;
  logic                       in_range;

  assign accept = in_valid_i && !in_stall_o;

  stpd_edge u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .item_i    (in_item_i),
    .thr_i     (thr_q),
    .eval_en_i (eval_en),
    .commit_i  (commit),
    .eval_o    (eval),
    .period_o  (period)
  );

  // floor(N / 2p) == floor(floor(N / 2) / p)
  assign num_sum = {1'b0, stpd_pkg::RATE_NUM_X2} + {1'b0, period};

  stpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_sum[stpd_pkg::DIV_W:1]),
    .divisor_i  (period),
    .done_o     (div_done),
    .rate_o     (rate)
  );

  assign bpm      = rate.quo[stpd_pkg::QUO_W-1:1];
  assign in_range = !rate.ovf && (bpm >= low_q) && (bpm <= high_q);

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    eval_en    = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    rate_ok_d  = rate_ok_q;
    unique case (state_q)
      stpd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = stpd_pkg::ST_EVAL;
        end
      end
      stpd_pkg::ST_EVAL: begin
        eval_en = 1'b1;
        state_d = stpd_pkg::ST_PREP;
      end
      stpd_pkg::ST_PREP: begin
        rate_ok_d = 1'b0;
        if (eval.edge_hit && !eval.period_zero) begin
          div_start = 1'b1;
          state_d   = stpd_pkg::ST_DIV;
        end else begin
          state_d = stpd_pkg::ST_DONE;
        end
      end
      stpd_pkg::ST_DIV: begin
        if (div_done) begin
          rate_ok_d = in_range;
          state_d   = stpd_pkg::ST_DONE;
        end
      end
      stpd_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = stpd_pkg::ST_IDLE;
        end
      end
      default: state_d = stpd_pkg::ST_IDLE;
    endcase
  end

  assign tempo_d     = (commit && rate_ok_q) ? bpm : tempo_q;
  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stpd_pkg::ST_IDLE;
      thr_q       <= stpd_pkg::THR_RESET;
      low_q       <= stpd_pkg::LOW_RESET;
      high_q      <= stpd_pkg::HIGH_RESET;
      tempo_q     <= stpd_pkg::TEMPO_RESET;
      rate_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tempo_q     <= tempo_d;
      rate_ok_q   <= rate_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          stpd_pkg::CFG_THRESHOLD:  thr_q  <= cfg_data_i;
          stpd_pkg::CFG_LOW_LIMIT:  low_q  <= cfg_data_i[stpd_pkg::BPM_W-1:0];
          stpd_pkg::CFG_HIGH_LIMIT: high_q <= cfg_data_i[stpd_pkg::BPM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.tempo_bpm     <= tempo_d;
      out_q.edge_seen     <= eval.edge_hit;
      out_q.tempo_changed <= rate_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- src/stpd_edge.sv -----
// ----------------------------------------------------------------------------
// stpd_edge: sample change and rising edge qualification
// Holds the item, the held sample and the last edge time; yields the period.
// ----------------------------------------------------------------------------
module stpd_edge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  stpd_pkg::stpd_in_t           item_i,
  input  logic [stpd_pkg::THR_W-1:0]   thr_i,
  input  logic                         eval_en_i,
  input  logic                         commit_i,
  output stpd_pkg::stpd_eval_t         eval_o,
  output logic [stpd_pkg::DIV_W-1:0]   period_o
);

  logic signed [15:0] sample_q;
  logic [31:0]        now_q;
  logic signed [15:0] held_q;
  logic [31:0]        last_q;
  stpd_pkg::stpd_eval_t eval_q, eval_d;
  logic [31:0]        period_q;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic signed [15:0] thr_s;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= item_i.sync_sample;
      now_q    <= item_i.now_us;
    end
    if (eval_en_i) begin
      period_q <= now_q - last_q;
    end
  end

  always_comb begin
    diff  = 17'(signed'({sample_q[15], sample_q})) - 17'(signed'({held_q[15], held_q}));
    mag   = diff[16] ? 17'(-diff) : 17'(diff);
    thr_s = signed'({1'b0, thr_i});
    eval_d.take        = mag > {2'b00, thr_i};
    eval_d.edge_hit    = eval_d.take && (held_q < thr_s) && (sample_q > thr_s);
    eval_d.period_zero = now_q == last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      last_q <= '0;
      eval_q <= '0;
    end else begin
      if (eval_en_i) begin
        eval_q <= eval_d;
      end
      if (commit_i && eval_q.take) begin
        held_q <= sample_q;
      end
      if (commit_i && eval_q.edge_hit) begin
        last_q <= now_q;
      end
    end
  end

  assign eval_o   = eval_q;
  assign period_o = period_q;

endmodule

// ----- src/stpd_div.sv -----
// ----------------------------------------------------------------------------
// stpd_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle, one quotient bit out per cycle.
// Keeps only the low quotient bits plus a sticky overflow flag.
// ----------------------------------------------------------------------------
module stpd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [stpd_pkg::DIV_W-1:0]   dividend_i,
  input  logic [stpd_pkg::DIV_W-1:0]   divisor_i,
  output logic                         done_o,
  output stpd_pkg::stpd_rate_t         rate_o
);

  logic [stpd_pkg::DIV_W-1:0] num_q, den_q, rem_q;
  logic [stpd_pkg::QUO_W-1:0] quo_q;
  logic                       ovf_q;
  logic [stpd_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q, done_q;

  logic [stpd_pkg::DIV_W:0]   trial;
  logic [stpd_pkg::DIV_W+1:0] sub;
  logic                       ge;

  always_comb begin
    trial = {rem_q, num_q[stpd_pkg::DIV_W-1]};
    sub   = {1'b0, trial} - {2'b00, den_q};
    ge    = !sub[stpd_pkg::DIV_W+1];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[stpd_pkg::DIV_W-2:0], 1'b0};
      // remainder stays below the divisor, so the low bits carry it all
      rem_q <= ge ? sub[stpd_pkg::DIV_W-1:0] : trial[stpd_pkg::DIV_W-1:0];
      quo_q <= {quo_q[stpd_pkg::QUO_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[stpd_pkg::QUO_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign rate_o.ovf = ovf_q;
  assign rate_o.quo = quo_q;

endmodule

// ----- src/stpd_chk.sv -----
// ----------------------------------------------------------------------------
// stpd_chk: port-level checks for the tempo detector
// Watches the top level's channels over time; bound to every instance.
// ----------------------------------------------------------------------------
module stpd_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input stpd_pkg::stpd_out_t         out_item_o
);

  // result register holds while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // a stored tempo only comes from a qualified edge
  a_changed_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.tempo_changed || out_item_o.edge_seen))
    else $error("tempo changed without an edge");

  // one item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in flight");

  // nothing comes out while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind sync_pulse_tempo_detector stpd_chk u_stpd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
